### sv/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// lfdc_pkg
// Shared types, codes and constants of the length-field deframer.
// ----------------------------------------------------------------------------
package lfdc_pkg;

  // Message header layout
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LEN_FIRST    = 4;
  localparam int unsigned LEN_LAST     = 7;

  // Magic cookie length
  localparam int unsigned COOKIE_BYTES = 16;

  // Request opcodes
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COOKIES_ENABLED  = 2'd0;
  localparam logic [1:0] REG_COOKIE_ID_BYTE   = 2'd1;
  localparam logic [1:0] REG_COOKIE_TYPE_BYTE = 2'd2;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_COOKIE = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       first_of_message;
    logic       last_of_message;
  } result_t;

  // Controls of one window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Controls and status of the framer
  typedef struct packed {
    logic step;
    logic clear;
  } framer_ctl_t;

  typedef struct packed {
    logic active;
    logic first;
    logic last;
  } framer_st_t;

  // Expected byte at each place of the cookie, oldest byte first
  function automatic logic [7:0] cookie_byte(input int unsigned idx,
                                             input logic [7:0] id_byte,
                                             input logic [7:0] msg_type);
    logic [7:0] b;
    unique case (idx)
      0, 1:    b = 8'hFF;
      2:       b = id_byte;
      7:       b = 8'h08;
      8:       b = 8'hDE;
      9:       b = 8'hAD;
      10:      b = 8'hBE;
      11:      b = 8'hEF;
      12, 13:  b = 8'h01;
      14:      b = msg_type;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/lfdc_stream_if.sv
// ----------------------------------------------------------------------------
// lfdc_stream_if
// Input channel: one stream byte or one resync request per transfer.
// ----------------------------------------------------------------------------
interface lfdc_stream_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

### sv/lfdc_result_if.sv
// ----------------------------------------------------------------------------
// lfdc_result_if
// Output channel: message bytes with boundary marks, resync and abort events.
// ----------------------------------------------------------------------------
interface lfdc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       first_of_message;
  logic       last_of_message;

  modport source (output valid, output kind, output out_byte,
                  output first_of_message, output last_of_message, input ready);
  modport sink   (input valid, input kind, input out_byte,
                  input first_of_message, input last_of_message, output ready);
endinterface

### sv/lfdc_cookie_cell.sv
// ----------------------------------------------------------------------------
// lfdc_cookie_cell
// One place of the cookie search window: holds a byte and its valid flag,
// takes its neighbor's byte on each shift and flags a match of that byte.
// ----------------------------------------------------------------------------
module lfdc_cookie_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  lfdc_pkg::cell_ctl_t   ctl,
  input  logic [7:0]            din,
  input  logic                  vin,
  input  logic [7:0]            pattern,
  output logic [7:0]            dout,
  output logic                  vout,
  output logic                  hit
);

  logic [7:0] data;
  logic       valid;

  // Flag whether the byte about to enter is valid and matches its pattern byte
  assign hit  = vin && (din == pattern);
  assign dout = data;
  assign vout = valid;

  // Valid flag: drop on clear, follow the neighbor on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= vin;
    end
  end

  // Byte: take the neighbor's byte on shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= din;
    end
  end

endmodule

### sv/lfdc_framer.sv
// ----------------------------------------------------------------------------
// lfdc_framer
// Tracks the position inside the current message, gathers the length field
// and marks the first and last byte of each message.
// ----------------------------------------------------------------------------
module lfdc_framer (
  input  logic                   clk,
  input  logic                   rst,
  input  lfdc_pkg::framer_ctl_t  ctl,
  input  logic [7:0]             data_byte,
  output lfdc_pkg::framer_st_t   st
);
  import lfdc_pkg::*;

  logic [32:0] pos;
  logic [31:0] length;
  logic [31:0] length_next;
  logic [33:0] total;
  logic [33:0] pos_plus;

  // Shift in length field bytes, big-endian
  always_comb begin
    if (pos == 33'd0) begin
      length_next = 32'd0;
    end else if (pos >= 33'(LEN_FIRST) && pos <= 33'(LEN_LAST)) begin
      length_next = {length[23:0], data_byte};
    end else begin
      length_next = length;
    end
    total    = 34'(HEADER_BYTES) + {2'b00, length_next};
    pos_plus = {1'b0, pos} + 34'd1;
    st.active = (pos != 33'd0);
    st.first  = (pos == 33'd0);
    st.last   = (pos >= 33'(HEADER_BYTES - 1)) && (pos_plus >= total);
  end

  // Position counter: restart after the last byte or on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 33'd0;
      length <= 32'd0;
    end else if (ctl.clear) begin
      pos    <= 33'd0;
      length <= 32'd0;
    end else if (ctl.step) begin
      length <= length_next;
      pos    <= st.last ? 33'd0 : pos_plus[32:0];
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && !ctl.clear && st.last) |=> (pos == 33'd0))
    else $error("framer did not restart after last byte");

endmodule

### sv/length_field_deframer_with_cookie_resync.sv
// ----------------------------------------------------------------------------
// length_field_deframer_with_cookie_resync
// Length-field message deframer with magic-cookie resynchronization.
// ----------------------------------------------------------------------------
// Takes one request per clock while ready: a stream byte or a resync. Outside
// a hunt each byte leaves, registered, as a message byte marked first/last,
// framed by the 8-byte header whose bytes 4 to 7 carry a big-endian length. A
// resync aborts the partial message (one abort result if one was open) and,
// with cookies enabled, starts a hunt in which bytes shift through a row of 16
// window cells; the cycle the last cookie byte arrives, all cells compare at
// once and one cookie result is given, after which framing restarts.
// Throughput is one request per cycle while ready, set by the position counter
// outside a hunt and the cell row in one, each updating once per request.
// Results go through an output register and a skid register, so the stream
// side stays ready while one result waits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module length_field_deframer_with_cookie_resync (
  input  logic                          clk,
  input  logic                          rst,
  lfdc_stream_if.sink                   stream,
  lfdc_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lfdc_pkg::*;

  logic        cookies_enabled;
  logic [7:0]  cookie_id_byte;
  logic [7:0]  cookie_type_byte;
  logic        hunting;

  logic        acc;
  logic        is_resync;
  logic        found;
  logic        push;
  result_t     new_res;

  cell_ctl_t   cell_ctl;
  framer_ctl_t framer_ctl;
  framer_st_t  framer_st;

  logic [7:0]              cell_byte [COOKIE_BYTES];
  logic [COOKIE_BYTES-1:0] cell_valid;
  logic [COOKIE_BYTES-1:0] hit;

  logic    out_valid;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cookies_enabled  <= 1'b0;
      cookie_id_byte   <= 8'd0;
      cookie_type_byte <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_COOKIES_ENABLED:  cookies_enabled  <= pwdata[0];
        REG_COOKIE_ID_BYTE:   cookie_id_byte   <= pwdata[7:0];
        REG_COOKIE_TYPE_BYTE: cookie_type_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COOKIES_ENABLED:  prdata = {31'd0, cookies_enabled};
      REG_COOKIE_ID_BYTE:   prdata = {24'd0, cookie_id_byte};
      REG_COOKIE_TYPE_BYTE: prdata = {24'd0, cookie_type_byte};
      default:              prdata = 32'd0;
    endcase
  end

  // Cookie window: a row of cells, oldest byte in cell 0
  for (genvar i = 0; i < COOKIE_BYTES; i++) begin : g_cell
    logic [7:0] din;
    logic       vin;
    if (i == COOKIE_BYTES - 1) begin : g_tail
      assign din = stream.data_byte;
      assign vin = 1'b1;
    end else begin : g_body
      assign din = cell_byte[i+1];
      assign vin = cell_valid[i+1];
    end
    lfdc_cookie_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl),
      .din     (din),
      .vin     (vin),
      .pattern (cookie_byte(i, cookie_id_byte, cookie_type_byte)),
      .dout    (cell_byte[i]),
      .vout    (cell_valid[i]),
      .hit     (hit[i])
    );
  end

  lfdc_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (framer_ctl),
    .data_byte (stream.data_byte),
    .st        (framer_st)
  );

  // Decode the request and build its result
  always_comb begin
    acc       = stream.valid && stream.ready;
    is_resync = (stream.opcode == OP_RESYNC);

    cell_ctl.shift = acc && !is_resync && hunting;
    found          = cell_ctl.shift && (&hit);
    cell_ctl.clear = (acc && is_resync && cookies_enabled) || found;

    framer_ctl.step  = acc && !is_resync && !hunting;
    framer_ctl.clear = (acc && is_resync) || found;

    new_res = '{kind: KIND_BYTE, out_byte: 8'd0,
                first_of_message: 1'b0, last_of_message: 1'b0};
    push = 1'b0;
    priority if (!acc) begin
      push = 1'b0;
    end else if (is_resync) begin
      push         = framer_st.active;
      new_res.kind = KIND_ABORT;
    end else if (hunting) begin
      push         = found;
      new_res.kind = KIND_COOKIE;
    end else begin
      push                     = 1'b1;
      new_res.kind             = KIND_BYTE;
      new_res.out_byte         = stream.data_byte;
      new_res.first_of_message = framer_st.first;
      new_res.last_of_message  = framer_st.last;
    end
  end

  // Hunt flag: start on resync with cookies enabled, end when a cookie is seen
  always_ff @(posedge clk) begin
    if (rst) begin
      hunting <= 1'b0;
    end else if (acc && is_resync && cookies_enabled) begin
      hunting <= 1'b1;
    end else if (found) begin
      hunting <= 1'b0;
    end
  end

  // Output register plus skid register
  assign stream.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= new_res;
      end else begin
        out_res <= new_res;
      end
    end else if (push) begin
      skid_res <= new_res;
    end
  end

  assign result.valid            = out_valid;
  assign result.kind             = out_res.kind;
  assign result.out_byte         = out_res.out_byte;
  assign result.first_of_message = out_res.first_of_message;
  assign result.last_of_message  = out_res.last_of_message;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a request while output register is empty");

  a_resync_closes: assert property (@(posedge clk) disable iff (rst)
    (acc && is_resync) |=> !framer_st.active)
    else $error("message still open after resync");

  a_cookie_ends_hunt: assert property (@(posedge clk) disable iff (rst)
    found |=> (!hunting && !cell_valid[COOKIE_BYTES-1]))
    else $error("hunt not ended after cookie");

  a_no_bytes_while_hunting: assert property (@(posedge clk) disable iff (rst)
    hunting |-> !framer_ctl.step)
    else $error("framer stepped during hunt");

endmodule
